>>> design/fsp_pkg.sv
package fsp_pkg;

    // parser phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FLAGS = 2'd1,
        PH_WIDTH = 2'd2,
        PH_PREC  = 2'd3
    } phase_t;

    // conversion kinds as reported on the result channel
    localparam logic [3:0] KIND_CHAR    = 4'd0;
    localparam logic [3:0] KIND_STRING  = 4'd1;
    localparam logic [3:0] KIND_POINTER = 4'd2;
    localparam logic [3:0] KIND_SIGNED  = 4'd3;
    localparam logic [3:0] KIND_UNSIGN  = 4'd4;
    localparam logic [3:0] KIND_HEXLO   = 4'd5;
    localparam logic [3:0] KIND_HEXUP   = 4'd6;
    localparam logic [3:0] KIND_PERCENT = 4'd7;
    localparam logic [3:0] KIND_ERROR   = 4'd8;

    // flag positions in the flag vector
    localparam int FLAG_ALT   = 0;
    localparam int FLAG_BLANK = 1;
    localparam int FLAG_SIGN  = 2;
    localparam int FLAG_LEFT  = 3;
    localparam int FLAG_ZERO  = 4;
    localparam int FLAG_COUNT = 5;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_NUM_W = 16;

    // one classified byte, passed from front to back
    typedef struct packed {
        logic                  is_flag;
        logic [FLAG_COUNT-1:0] flag_mask;
        logic                  is_digit;
        logic [3:0]            digit;
        logic                  is_dot;
        logic [3:0]            kind;
    } token_t;

    typedef struct packed {
        logic [3:0]            kind;
        logic [FLAG_COUNT-1:0] flags;
        logic                  has_width;
        logic [OUT_NUM_W-1:0]  min_width;
        logic                  has_precision;
        logic [OUT_NUM_W-1:0]  precision_value;
    } result_t;

    function automatic logic [3:0] classify(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            8'h63:        k = KIND_CHAR;
            8'h73:        k = KIND_STRING;
            8'h70:        k = KIND_POINTER;
            8'h64, 8'h69: k = KIND_SIGNED;
            8'h75:        k = KIND_UNSIGN;
            8'h78:        k = KIND_HEXLO;
            8'h58:        k = KIND_HEXUP;
            8'h25:        k = KIND_PERCENT;
            default:      k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

>>> design/fsp_front.sv
module fsp_front
    import fsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_ch,
    output logic       tok_valid,
    input  logic       tok_ready,
    output token_t     tok
);

    logic   valid_reg;
    logic   valid_next;
    token_t tok_reg;
    token_t tok_next;

    assign in_ready  = !valid_reg || tok_ready;
    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

    always_comb begin
        tok_next.flag_mask = '0;
        unique case (in_ch)
            CH_HASH:  tok_next.flag_mask[FLAG_ALT]   = 1'b1;
            CH_SPACE: tok_next.flag_mask[FLAG_BLANK] = 1'b1;
            CH_PLUS:  tok_next.flag_mask[FLAG_SIGN]  = 1'b1;
            CH_MINUS: tok_next.flag_mask[FLAG_LEFT]  = 1'b1;
            CH_ZERO:  tok_next.flag_mask[FLAG_ZERO]  = 1'b1;
            default:  tok_next.flag_mask = '0;
        endcase
        tok_next.is_flag  = |tok_next.flag_mask;
        tok_next.is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
        tok_next.digit    = 4'(in_ch - CH_ZERO);
        tok_next.is_dot   = (in_ch == CH_DOT);
        tok_next.kind     = classify(in_ch);
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (tok_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            tok_reg <= tok_next;
        end
    end

endmodule

>>> design/fsp_queue.sv
module fsp_queue
    import fsp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    output logic   push_ready,
    input  token_t push_tok,
    output logic   pop_valid,
    input  logic   pop_ready,
    output token_t pop_tok
);

    token_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

>>> design/fsp_back.sv
module fsp_back
    import fsp_pkg::*;
#(
    parameter int NUMBER_BITS = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    tok_valid,
    output logic    tok_ready,
    input  token_t  tok,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int SUM_W = NUMBER_BITS + 4;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [FLAG_COUNT-1:0] flags_reg;
    logic [FLAG_COUNT-1:0] flags_next;
    logic                  width_seen_reg;
    logic                  width_seen_next;
    logic [NUMBER_BITS-1:0] width_acc_reg;
    logic [NUMBER_BITS-1:0] width_acc_next;
    logic                  dot_seen_reg;
    logic                  dot_seen_next;
    logic [NUMBER_BITS-1:0] prec_acc_reg;
    logic [NUMBER_BITS-1:0] prec_acc_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_reg;
    result_t               out_next;

    logic                   term;
    logic                   take;
    logic [NUMBER_BITS-1:0] acc_src;
    logic [SUM_W-1:0]       acc_ext;
    logic [SUM_W-1:0]       acc_sum;
    logic [NUMBER_BITS-1:0] acc_sat;
    logic [31:0]            width_wide;
    logic [31:0]            prec_wide;

    // one shared times-ten-plus-digit unit, saturating at the top of the range
    assign acc_src = (phase_reg == PH_PREC) ? prec_acc_reg : width_acc_reg;
    assign acc_ext = SUM_W'(acc_src);
    assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(tok.digit);
    assign acc_sat = (acc_sum > SUM_W'({NUMBER_BITS{1'b1}})) ? {NUMBER_BITS{1'b1}}
                                                          : acc_sum[NUMBER_BITS-1:0];

    // does this byte end the specification
    always_comb begin
        unique case (phase_reg)
            PH_IDLE:  term = 1'b0;
            PH_FLAGS: term = !(tok.is_flag || tok.is_digit || tok.is_dot);
            PH_WIDTH: term = !(tok.is_digit || tok.is_dot);
            PH_PREC:  term = !tok.is_digit;
            default:  term = 1'b0;
        endcase
    end

    assign take      = tok_valid && (!term || !out_valid_reg || res_ready);
    assign tok_ready = take;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            unique case (phase_reg)
                PH_IDLE: phase_next = PH_FLAGS;
                PH_FLAGS: begin
                    priority if (tok.is_flag) begin
                        phase_next = PH_FLAGS;
                    end else if (tok.is_digit) begin
                        phase_next = PH_WIDTH;
                    end else if (tok.is_dot) begin
                        phase_next = PH_PREC;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_WIDTH: begin
                    priority if (tok.is_digit) begin
                        phase_next = PH_WIDTH;
                    end else if (tok.is_dot) begin
                        phase_next = PH_PREC;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_PREC: phase_next = tok.is_digit ? PH_PREC : PH_IDLE;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    assign width_wide = 32'(width_acc_reg);
    assign prec_wide  = 32'(prec_acc_reg);

    // collected fields and result register
    always_comb begin
        flags_next      = flags_reg;
        width_seen_next = width_seen_reg;
        width_acc_next  = width_acc_reg;
        dot_seen_next   = dot_seen_reg;
        prec_acc_next   = prec_acc_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_next        = out_reg;

        if (take) begin
            if (term || phase_reg == PH_IDLE) begin
                flags_next      = '0;
                width_seen_next = 1'b0;
                width_acc_next  = '0;
                dot_seen_next   = 1'b0;
                prec_acc_next   = '0;
            end
            if (term) begin
                // result is loaded only when the terminating byte is taken
                out_valid_next           = 1'b1;
                out_next.kind            = tok.kind;
                out_next.flags           = flags_reg;
                out_next.has_width       = width_seen_reg;
                out_next.min_width       = width_wide[OUT_NUM_W-1:0];
                out_next.has_precision   = dot_seen_reg;
                out_next.precision_value = prec_wide[OUT_NUM_W-1:0];
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_FLAGS: begin
                        priority if (tok.is_flag) begin
                            flags_next = flags_reg | tok.flag_mask;
                        end else if (tok.is_digit) begin
                            width_seen_next = 1'b1;
                            width_acc_next  = acc_sat;
                        end else begin
                            dot_seen_next = 1'b1;
                        end
                    end
                    PH_WIDTH: begin
                        if (tok.is_digit) begin
                            width_acc_next = acc_sat;
                        end else begin
                            dot_seen_next = 1'b1;
                        end
                    end
                    PH_PREC: prec_acc_next = acc_sat;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            flags_reg      <= '0;
            width_seen_reg <= 1'b0;
            width_acc_reg  <= '0;
            dot_seen_reg   <= 1'b0;
            prec_acc_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            flags_reg      <= flags_next;
            width_seen_reg <= width_seen_next;
            width_acc_reg  <= width_acc_next;
            dot_seen_reg   <= dot_seen_next;
            prec_acc_reg   <= prec_acc_next;
            out_valid_reg  <= out_valid_next;
        end
        out_reg <= out_next;
    end

endmodule

>>> design/format_spec_parser.sv
// printf-style conversion specification parser. bytes of one specification
// arrive one per slave transaction, the introducer first (its value is not
// checked). flags '#', ' ', '+', '-', '0' are collected, then a decimal width,
// then an optional '.' and decimal precision; the first byte that fits none of
// these ends the specification and yields exactly one master transaction with
// the conversion kind (0 c, 1 s, 2 p, 3 d/i, 4 u, 5 x, 6 X, 7 percent,
// 8 error) plus everything collected. width and precision saturate at
// 2^NUMBER_BITS-1 and are reported in 16-bit fields. the block takes one byte
// every cycle for as long as the master side keeps up; a byte passes a
// classifying register, a two-entry queue and the parsing stage, whose result
// register drives m_axis. the parsing stage holds one multiply-by-ten-and-add
// per cycle, which sets the clock limit; no clearing pass follows reset
module format_spec_parser
    import fsp_pkg::*;
#(
    parameter int NUMBER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] conversion_kind, [4] alt_form, [5] blank_flag, [6] sign_flag,
    // [7] left_flag, [8] zero_pad, [9] has_width, [25:10] min_width,
    // [26] has_precision, [42:27] precision_value, [47:43] zero
    output logic [47:0] m_axis_tdata
);

    // front to queue
    logic    ft_valid;
    logic    ft_ready;
    token_t  ft_tok;

    // queue to back
    logic    qb_valid;
    logic    qb_ready;
    token_t  qb_tok;

    result_t res;

    // byte classification, one per cycle while the queue has room
    fsp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_ch     (s_axis_tdata),
        .tok_valid (ft_valid),
        .tok_ready (ft_ready),
        .tok       (ft_tok)
    );

    // short queue decoupling front and back stalls
    fsp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (ft_valid),
        .push_ready (ft_ready),
        .push_tok   (ft_tok),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_tok    (qb_tok)
    );

    // phase tracking, number accumulation and result register
    fsp_back #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (qb_valid),
        .tok_ready (qb_ready),
        .tok       (qb_tok),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // pack result fields, highest field first, kind in the lowest bits
    assign m_axis_tdata = {
        5'b0,
        res.precision_value,
        res.has_precision,
        res.min_width,
        res.has_width,
        res.flags[FLAG_ZERO],
        res.flags[FLAG_LEFT],
        res.flags[FLAG_SIGN],
        res.flags[FLAG_BLANK],
        res.flags[FLAG_ALT],
        res.kind
    };

endmodule

>>> tb/tb_format_spec_parser.sv
`timescale 1ns / 1ps

module tb_format_spec_parser;
    import fsp_pkg::*;

    localparam int NUMBER_BITS_TB = 16;
    localparam int unsigned NUM_CAP = (1 << NUMBER_BITS_TB) - 1;
    localparam int HOLD_CYCLES = 300;

    // one parsed specification as it appears on the master side
    typedef struct {
        logic [3:0]            kind;
        logic [FLAG_COUNT-1:0] flags;
        logic                  has_width;
        logic [OUT_NUM_W-1:0]  min_width;
        logic                  has_prec;
        logic [OUT_NUM_W-1:0]  prec;
    } spec_fields_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;      // [7:0] ch
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] conversion_kind, [4] alt_form, [5] blank_flag, [6] sign_flag,
    // [7] left_flag, [8] zero_pad, [9] has_width, [25:10] min_width,
    // [26] has_precision, [42:27] precision_value, [47:43] zero
    logic [47:0] m_axis_tdata;

    // bytes waiting for the driver, parsed specs waiting for the monitor
    logic [7:0]   pending_bytes[$];
    spec_fields_t spec_results[$];

    int mismatches = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;

    // shadow copy of the parser state
    phase_t                parse_phase = PH_IDLE;
    logic [FLAG_COUNT-1:0] seen_flags = '0;
    logic                  width_seen = 1'b0;
    logic [OUT_NUM_W-1:0]  width_acc = '0;
    logic                  dot_seen = 1'b0;
    logic [OUT_NUM_W-1:0]  prec_acc = '0;

    format_spec_parser #(
        .NUMBER_BITS(NUMBER_BITS_TB)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // reset held from the start, then released for good
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // -----------------------------------------------------------------
    // predictor
    // -----------------------------------------------------------------

    function automatic int flag_position(input logic [7:0] c);
        case (c)
            CH_HASH:  return FLAG_ALT;
            CH_SPACE: return FLAG_BLANK;
            CH_PLUS:  return FLAG_SIGN;
            CH_MINUS: return FLAG_LEFT;
            CH_ZERO:  return FLAG_ZERO;
            default:  return -1;
        endcase
    endfunction

    function automatic logic [3:0] kind_of_letter(input logic [7:0] c);
        case (c)
            "c":      return KIND_CHAR;
            "s":      return KIND_STRING;
            "p":      return KIND_POINTER;
            "d", "i": return KIND_SIGNED;
            "u":      return KIND_UNSIGN;
            "x":      return KIND_HEXLO;
            "X":      return KIND_HEXUP;
            "%":      return KIND_PERCENT;
            default:  return KIND_ERROR;
        endcase
    endfunction

    // decimal accumulate, sticking at the top of the number range
    function automatic logic [OUT_NUM_W-1:0] shift_in_digit(input logic [OUT_NUM_W-1:0] acc,
                                                             input logic [3:0] digit);
        int unsigned next;
        next = acc * 10 + digit;
        return (next > NUM_CAP) ? NUM_CAP[OUT_NUM_W-1:0] : next[OUT_NUM_W-1:0];
    endfunction

    task automatic clear_spec_state();
        seen_flags = '0;
        width_seen = 1'b0;
        width_acc  = '0;
        dot_seen   = 1'b0;
        prec_acc   = '0;
    endtask

    // advance the shadow parser by one accepted byte; a terminating byte
    // queues the parsed spec
    task automatic parse_spec_byte(input logic [7:0] c);
        spec_fields_t r;
        logic         is_digit;
        logic         done;
        int           fpos;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        fpos = flag_position(c);
        done = 1'b0;
        case (parse_phase)
            PH_IDLE: begin
                // introducer, any value
                clear_spec_state();
                parse_phase = PH_FLAGS;
            end
            PH_FLAGS: begin
                if (fpos >= 0) begin
                    seen_flags[fpos] = 1'b1;
                end else if (is_digit) begin
                    width_seen = 1'b1;
                    width_acc = shift_in_digit(width_acc, c[3:0]);
                    parse_phase = PH_WIDTH;
                end else if (c == CH_DOT) begin
                    dot_seen = 1'b1;
                    parse_phase = PH_PREC;
                end else begin
                    done = 1'b1;
                end
            end
            PH_WIDTH: begin
                if (is_digit) begin
                    width_acc = shift_in_digit(width_acc, c[3:0]);
                end else if (c == CH_DOT) begin
                    dot_seen = 1'b1;
                    parse_phase = PH_PREC;
                end else begin
                    done = 1'b1;
                end
            end
            default: begin
                if (is_digit) begin
                    prec_acc = shift_in_digit(prec_acc, c[3:0]);
                end else begin
                    done = 1'b1;
                end
            end
        endcase
        if (done) begin
            r.kind      = kind_of_letter(c);
            r.flags     = seen_flags;
            r.has_width = width_seen;
            r.min_width = width_acc;
            r.has_prec  = dot_seen;
            r.prec      = prec_acc;
            spec_results.push_back(r);
            parse_phase = PH_IDLE;
            clear_spec_state();
        end
    endtask

    // -----------------------------------------------------------------
    // driver: one byte per slave transaction, valid held until taken
    // -----------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_spec_byte(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_bytes.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------
    // receiver ready: random stalls plus a long hold-off,
    // started by a toggle of hold_req and counted here
    // -----------------------------------------------------------------
    int hold_left;
    bit hold_ack;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_ack      <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // -----------------------------------------------------------------
    // monitor: every master transaction against the oldest parsed spec
    // -----------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    string flag_names[FLAG_COUNT] = '{"alt_form", "blank_flag", "sign_flag",
                                      "left_flag", "zero_pad"};

    always @(posedge aclk) begin : result_check
        spec_fields_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (spec_results.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = spec_results.pop_front();
                check_field("conversion_kind", want.kind, m_axis_tdata[3:0]);
                for (int i = 0; i < FLAG_COUNT; i++) begin
                    check_field(flag_names[i], want.flags[i], m_axis_tdata[4+i]);
                end
                check_field("has_width", want.has_width, m_axis_tdata[9]);
                check_field("min_width", want.min_width, m_axis_tdata[25:10]);
                check_field("has_precision", want.has_prec, m_axis_tdata[26]);
                check_field("precision_value", want.prec, m_axis_tdata[42:27]);
                check_field("pad", 16'd0, m_axis_tdata[47:43]);
            end
        end
    end

    // -----------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            pending_bytes.push_back(s[i]);
        end
    endtask

    task automatic push_digits(input int count);
        for (int i = 0; i < count; i++) begin
            pending_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    // mostly well-formed specs with random content, some broken ones and noise
    task automatic add_random_specs(input int target);
        string      letters;
        logic [7:0] flag_chars[5];
        int         start;
        int         r;
        letters = "cspdiuxX%";
        flag_chars = '{CH_HASH, CH_SPACE, CH_PLUS, CH_MINUS, CH_ZERO};
        start = pending_bytes.size();
        while (pending_bytes.size() - start < target) begin
            if ($urandom_range(99) < 8) begin
                // noise run, parsed as whatever it happens to be
                repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom_range(255)));
            end else begin
                // introducer, any byte value
                pending_bytes.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                                  : 8'h25);
                repeat ($urandom_range(0, 3)) begin
                    pending_bytes.push_back(flag_chars[$urandom_range(4)]);
                end
                r = $urandom_range(99);
                if (r >= 40) begin
                    push_digits((r < 92) ? $urandom_range(1, 3) : $urandom_range(4, 7));
                end
                if ($urandom_range(99) < 45) begin
                    pending_bytes.push_back(CH_DOT);
                    r = $urandom_range(99);
                    if (r >= 25) begin
                        push_digits((r < 92) ? $urandom_range(1, 3) : $urandom_range(4, 7));
                    end
                end
                r = $urandom_range(99);
                if (r < 70) begin
                    pending_bytes.push_back(letters[$urandom_range(letters.len() - 1)]);
                end else if (r < 80) begin
                    pending_bytes.push_back(8'($urandom_range(255)));
                end else if (r < 87) begin
                    pending_bytes.push_back(flag_chars[$urandom_range(4)]);
                end else if (r < 93) begin
                    pending_bytes.push_back(CH_DOT);
                end else begin
                    pending_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                end
            end
        end
    endtask

    task automatic wait_sent();
        while (pending_bytes.size() != 0 || s_axis_tvalid) @(negedge aclk);
    endtask

    initial begin
        // directed: introducer extremes, every kind, every flag, bare dot,
        // saturated width, flag after digits, second dot, unknown letter
        pending_bytes.push_back(8'h00);
        push_text("c");
        pending_bytes.push_back(8'hFF);
        push_text("#s");
        push_text("%+ p");
        push_text("%-0d");
        push_text("%i");
        push_text("%7u");
        push_text("%.x");
        push_text("%70000X");
        push_text("%%");
        push_text("%3-d");
        push_text("%..s");
        push_text("%q");

        @(posedge aresetn);
        wait_sent();

        // no idling, with a long receiver hold-off so the input backs up
        @(negedge aclk);
        hold_req = ~hold_req;
        add_random_specs(400);
        wait_sent();

        @(negedge aclk);
        sender_idle_pct = 65;
        recv_stall_pct = 0;
        add_random_specs(400);
        wait_sent();

        @(negedge aclk);
        sender_idle_pct = 0;
        recv_stall_pct = 65;
        add_random_specs(400);
        wait_sent();

        @(negedge aclk);
        sender_idle_pct = 30;
        recv_stall_pct = 30;
        add_random_specs(400);
        wait_sent();

        // drain, then a few cycles more for anything stray
        while (spec_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
design/fsp_pkg.sv
design/fsp_front.sv
design/fsp_queue.sv
design/fsp_back.sv
design/format_spec_parser.sv
tb/tb_format_spec_parser.sv
